>>> src/m68ksr_pkg.sv
// Shared types, constants and helper functions for the 68000 shift and rotate unit.
package m68ksr_pkg;

    // Operation kinds as encoded in the opcode type field
    typedef enum logic [1:0] {
        SHT_AS  = 2'd0,
        SHT_LS  = 2'd1,
        SHT_ROX = 2'd2,
        SHT_RO  = 2'd3
    } shift_type_t;

    // Operand sizes
    typedef enum logic [1:0] {
        SZ_BYTE = 2'd0,
        SZ_WORD = 2'd1,
        SZ_LONG = 2'd2
    } size_t;

    // Size field code that selects the memory form
    localparam logic [1:0] SIZE_FIELD_MEM = 2'd3;

    // Immediate count field of zero stands for this count
    localparam logic [5:0] COUNT_IMM_ZERO = 6'd8;

    // Memory form always shifts once
    localparam logic [5:0] COUNT_MEM = 6'd1;

    // Rotate-through-extend lengths (operand width plus the X bit)
    localparam logic [5:0] ROX_LEN_BYTE = 6'd9;
    localparam logic [5:0] ROX_LEN_WORD = 6'd17;
    localparam logic [5:0] ROX_LEN_LONG = 6'd33;

    // Decoded operation
    typedef struct packed {
        shift_type_t kind;
        size_t       size;
        logic        left;
        logic [5:0]  count;
    } dec_t;

    // Computed result word and flags
    typedef struct packed {
        logic [31:0] value;
        logic        x;
        logic        n;
        logic        z;
        logic        v;
        logic        c;
    } res_t;

    function automatic logic [31:0] size_mask(size_t sz);
        logic [31:0] m;
        case (sz)
            SZ_BYTE: m = 32'h0000_00FF;
            SZ_WORD: m = 32'h0000_FFFF;
            default: m = 32'hFFFF_FFFF;
        endcase
        return m;
    endfunction

    function automatic logic [31:0] size_msb(size_t sz);
        logic [31:0] m;
        case (sz)
            SZ_BYTE: m = 32'h0000_0080;
            SZ_WORD: m = 32'h0000_8000;
            default: m = 32'h8000_0000;
        endcase
        return m;
    endfunction

    function automatic logic [5:0] size_width(size_t sz);
        logic [5:0] w;
        case (sz)
            SZ_BYTE: w = 6'd8;
            SZ_WORD: w = 6'd16;
            default: w = 6'd32;
        endcase
        return w;
    endfunction

    // Remainder of a count below 64 by a short constant length:
    // count the multiples passed in parallel, then subtract once
    function automatic logic [5:0] mod_small(logic [5:0] n, logic [5:0] len);
        int k;
        k = 0;
        for (int j = 1; j <= 7; j++) begin
            if ({26'd0, n} >= (j * int'(len))) begin
                k = k + 1;
            end
        end
        return n - 6'(k * int'(len));
    endfunction

endpackage

>>> src/m68ksr_decode.sv
// Opcode decoder: operation kind, size, direction and effective count.
module m68ksr_decode (
    input  logic [15:0]        opcode,
    input  logic [31:0]        count_source,
    output m68ksr_pkg::dec_t   dec
);
    import m68ksr_pkg::*;

    // Split register and memory forms
    always_comb begin
        dec.left = opcode[8];
        if (opcode[7:6] == SIZE_FIELD_MEM) begin
            dec.size  = SZ_WORD;
            dec.kind  = shift_type_t'(opcode[10:9]);
            dec.count = COUNT_MEM;
        end else begin
            case (opcode[7:6])
                2'd0:    dec.size = SZ_BYTE;
                2'd1:    dec.size = SZ_WORD;
                default: dec.size = SZ_LONG;
            endcase
            dec.kind = shift_type_t'(opcode[4:3]);
            if (opcode[5]) begin
                dec.count = (opcode[11:9] == 3'd0) ? COUNT_IMM_ZERO : {3'd0, opcode[11:9]};
            end else begin
                dec.count = count_source[5:0];
            end
        end
    end

endmodule

>>> src/m68ksr_core.sv
// Barrel shift and rotate datapath with flag generation.
module m68ksr_core (
    input  m68ksr_pkg::dec_t   dec,
    input  logic [31:0]        operand_value,
    input  logic               extend_in,
    output m68ksr_pkg::res_t   res
);
    import m68ksr_pkg::*;

    logic [31:0]        mask;
    logic [31:0]        msb;
    logic [5:0]         w;
    logic [31:0]        v;
    logic signed [31:0] sv;
    logic [5:0]         n;
    logic [5:0]         nm1;
    logic               nz;

    logic [31:0]        lsl_val;
    logic [31:0]        lsr_val;
    logic [31:0]        asr_val;
    logic               c_left;
    logic               c_lsr;
    logic               c_asr;
    logic [31:0]        topm;
    logic               v_asl;

    logic [5:0]         ro_amt;
    logic [31:0]        rol_val;
    logic [31:0]        ror_val;

    logic [5:0]         rox_len;
    logic [5:0]         rox_rem;
    logic [5:0]         rox_sh;
    logic [65:0]        rox_ext;
    logic [65:0]        rox_lmask;
    logic [65:0]        rox_rot;
    logic [65:0]        rox_top;
    logic [31:0]        rox_val;
    logic               rox_x;

    logic [31:0]        val;
    logic               c_sel;
    logic               x_sel;
    logic               v_sel;

    function automatic logic lsr_bit(logic [31:0] x);
        return x[0];
    endfunction

    // Size the operand
    always_comb begin
        mask = size_mask(dec.size);
        msb  = size_msb(dec.size);
        w    = size_width(dec.size);
        v    = operand_value & mask;
        n    = dec.count;
        nz   = (n != 6'd0);
        nm1  = n - 6'd1;
        case (dec.size)
            SZ_BYTE: sv = $signed({{24{operand_value[7]}}, operand_value[7:0]});
            SZ_WORD: sv = $signed({{16{operand_value[15]}}, operand_value[15:0]});
            default: sv = $signed(operand_value);
        endcase
    end

    // Plain and arithmetic shifts; the last bit out comes from a shift by one less
    always_comb begin
        lsl_val = (v << n) & mask;
        lsr_val = v >> n;
        asr_val = 32'(sv >>> n) & mask;
        c_left  = ((v << nm1) & msb) != 32'd0;
        c_lsr   = lsr_bit(v >> nm1);
        c_asr   = lsr_bit(32'(sv >>> nm1));
    end

    // ASL overflow: top count+1 bits not all equal, or any bit set once all are shifted out
    always_comb begin
        topm = mask & ~(mask >> ({1'b0, n} + 7'd1));
        if (n >= w) begin
            v_asl = (v != 32'd0);
        end else begin
            v_asl = ((v & topm) != 32'd0) && ((v & topm) != topm);
        end
    end

    // Rotate within the operand width
    always_comb begin
        ro_amt  = n & (w - 6'd1);
        rol_val = ((v << ro_amt) | (v >> (w - ro_amt))) & mask;
        ror_val = ((v >> ro_amt) | (v << (w - ro_amt))) & mask;
    end

    // Rotate through X over width plus one bits
    always_comb begin
        case (dec.size)
            SZ_BYTE: rox_len = ROX_LEN_BYTE;
            SZ_WORD: rox_len = ROX_LEN_WORD;
            default: rox_len = ROX_LEN_LONG;
        endcase
        rox_rem   = mod_small(n, rox_len);
        rox_sh    = dec.left ? rox_rem : (rox_len - rox_rem);
        rox_ext   = 66'(v) | (66'(extend_in) << w);
        rox_lmask = (66'd1 << rox_len) - 66'd1;
        rox_rot   = ((rox_ext << rox_sh) | (rox_ext >> (rox_len - rox_sh))) & rox_lmask;
        rox_val   = rox_rot[31:0] & mask;
        rox_top   = rox_rot >> w;
        rox_x     = rox_top[0];
    end

    // Select by operation and form the flags
    always_comb begin
        v_sel = 1'b0;
        case (dec.kind)
            SHT_AS: begin
                val   = dec.left ? lsl_val : asr_val;
                c_sel = nz & (dec.left ? c_left : c_asr);
                x_sel = nz ? c_sel : extend_in;
                v_sel = dec.left & v_asl;
            end
            SHT_LS: begin
                val   = dec.left ? lsl_val : lsr_val;
                c_sel = nz & (dec.left ? c_left : c_lsr);
                x_sel = nz ? c_sel : extend_in;
            end
            SHT_ROX: begin
                val   = rox_val;
                c_sel = rox_x;
                x_sel = rox_x;
            end
            default: begin
                val   = dec.left ? rol_val : ror_val;
                c_sel = nz & (dec.left ? val[0] : ((val & msb) != 32'd0));
                x_sel = extend_in;
            end
        endcase
        res.value = (operand_value & ~mask) | val;
        res.x     = x_sel;
        res.n     = (val & msb) != 32'd0;
        res.z     = (val == 32'd0);
        res.v     = v_sel;
        res.c     = c_sel;
    end

endmodule

>>> src/m68k_shift_rotate_unit.sv
// Top level of the 68000 shift and rotate unit: input register, datapath, result register.
// An accepted input word passes through the input register and then the result register before m_valid.
// Throughput: one word per cycle; both registers advance whenever the result register is empty
// or its word is being taken.
// The path between the registers is the decoder plus one barrel shifter and flag logic.
// Reset (aresetn low, synchronous) empties both registers; payload is not cleared.
module m68k_shift_rotate_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [15:0] s_opcode,
    input  logic [31:0] s_operand_value,
    input  logic [31:0] s_count_source,
    input  logic        s_extend_in,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_result_value,
    output logic        m_extend_out,
    output logic        m_negative_out,
    output logic        m_zero_out,
    output logic        m_overflow_out,
    output logic        m_carry_flag
);
    import m68ksr_pkg::*;

    logic        in_valid_reg;
    logic        in_valid_next;
    logic [15:0] opcode_reg;
    logic [31:0] operand_reg;
    logic [31:0] count_reg;
    logic        extend_reg;

    logic        out_valid_reg;
    logic        out_valid_next;
    res_t        res_reg;

    dec_t        dec;
    res_t        res;
    logic        advance;
    logic        take_in;

    // Advance when the result slot is free or being emptied
    assign advance = !out_valid_reg || m_ready;
    assign s_ready = !in_valid_reg || advance;
    assign take_in = s_valid && s_ready;

    always_comb begin
        if (take_in) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end else begin
            in_valid_next = in_valid_reg;
        end
        out_valid_next = advance ? in_valid_reg : out_valid_reg;
    end

    // Hold valid flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Capture the input word
    always_ff @(posedge aclk) begin
        if (take_in) begin
            opcode_reg  <= s_opcode;
            operand_reg <= s_operand_value;
            count_reg   <= s_count_source;
            extend_reg  <= s_extend_in;
        end
    end

    m68ksr_decode u_decode (
        .opcode       (opcode_reg),
        .count_source (count_reg),
        .dec          (dec)
    );

    m68ksr_core u_core (
        .dec           (dec),
        .operand_value (operand_reg),
        .extend_in     (extend_reg),
        .res           (res)
    );

    // Capture the result word
    always_ff @(posedge aclk) begin
        if (advance && in_valid_reg) begin
            res_reg <= res;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_result_value = res_reg.value;
    assign m_extend_out   = res_reg.x;
    assign m_negative_out = res_reg.n;
    assign m_zero_out     = res_reg.z;
    assign m_overflow_out = res_reg.v;
    assign m_carry_flag   = res_reg.c;

endmodule
